/* src/aksr_pkg.sv */
// Shared constants and helpers for the aging key set with rank.
// No dependencies; used by aging_key_set_with_rank_top.
package aksr_pkg;

   // request action codes
   localparam logic [1:0] ACT_MARK   = 2'd0;
   localparam logic [1:0] ACT_EXPIRE = 2'd1;
   localparam logic [1:0] ACT_RANK   = 2'd2;

   // field widths fixed by the interface
   localparam int KEY_W   = 7;
   localparam int NOW_W   = 32;
   localparam int DELAY_W = 32;
   localparam int COUNT_W = 8;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd3;

   // clamp a count to the 8-bit result range
   function automatic logic [COUNT_W-1:0] sat8(input logic [15:0] value);
      sat8 = (value > 16'd255) ? 8'd255 : value[COUNT_W-1:0];
   endfunction

endpackage

/* src/aging_key_set_with_rank_top.sv */
// Top level of the aging key set with rank: sequencer, presence flags and counters.
// Depends on aksr_pkg and aksr_ram (time stamp store).
//  - Request channel (req_valid/req_ready): action, key, now. Mark sets the key present
//    and stamps it with now; expire drops every key whose age (now - stamp, modulo
//    2^TIME_BITS) is at least expiry_delay and publishes the remaining count; rank
//    returns the present keys below key, or the total when key is absent.
//  - Response channel (rsp_valid/rsp_ready): exactly one response per request, with
//    rank, key_present and the published active count.
//  - Configuration: csr_wr_en/csr_wr_data write expiry_delay; write only while the block
//    is idle.
//  - Sequencing: a mark or the spare code goes straight to the result state; a rank query
//    and an expire sweep the keys first. Both sweeps step one key per cycle; expire also
//    waits for the registered stamp read that feeds the single subtract-and-compare unit.
//  - Request flow: req_ready is high only when idle, so a new request is taken only once
//    the previous one has left its result state. The next request may be accepted
//    while the previous response still waits in the output register; a stalled receiver
//    holds the response and the sequencer waits in its result state until it frees up.
//  - Reset (synchronous, active high) clears the presence flags, the published count and
//    the handshake state and sets expiry_delay to 3. The stamp RAM is not cleared.
module aging_key_set_with_rank_top #(
   parameter int KEY_COUNT = 128,
   parameter int TIME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [aksr_pkg::KEY_W-1:0]    req_key,
   input  logic [aksr_pkg::NOW_W-1:0]    req_now,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [aksr_pkg::COUNT_W-1:0]  rsp_rank,
   output logic                          rsp_key_present,
   output logic [aksr_pkg::COUNT_W-1:0]  rsp_active_count,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [aksr_pkg::DELAY_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(KEY_COUNT);
   localparam int CNT_W = $clog2(KEY_COUNT + 1);
   // compare width wide enough for both age and delay
   localparam int CMP_W = (TIME_BITS > aksr_pkg::DELAY_W) ? TIME_BITS : aksr_pkg::DELAY_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_COUNT - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXPIRE,
      S_EXP_LAST,
      S_RANK,
      S_RESULT
   } state_type;

   state_type                     state_ff, state_in;
   logic [KEY_COUNT-1:0]          present_ff, present_in;
   logic [aksr_pkg::DELAY_W-1:0]  delay_ff, delay_in;
   logic [aksr_pkg::COUNT_W-1:0]  published_ff, published_in;
   logic [1:0]                    op_ff, op_in;
   logic [aksr_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [TIME_BITS-1:0]          now_ff, now_in;
   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              sweep_ff, sweep_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]              total_ff, total_in;
   logic [CNT_W-1:0]              below_ff, below_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [aksr_pkg::COUNT_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [aksr_pkg::COUNT_W-1:0]  rsp_active_ff, rsp_active_in;

   // request decode
   logic [31:0]          key_wide;
   logic [IDX_W-1:0]     key_idx;
   logic                 key_in_range;
   logic [CMP_W-1:0]     now_wide;
   logic [TIME_BITS-1:0] now_t;

   // stamp store and the shared age unit
   logic                 ram_we;
   logic [TIME_BITS-1:0] stamp;
   logic [TIME_BITS-1:0] age;
   logic                 stale;

   assign key_wide     = 32'(req_key);
   assign key_idx      = key_wide[IDX_W-1:0];
   assign key_in_range = key_wide < 32'(KEY_COUNT);
   assign now_wide     = CMP_W'(req_now);
   assign now_t        = now_wide[TIME_BITS-1:0];

   aksr_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (KEY_COUNT)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (key_idx),
      .wr_data (now_t),
      .rd_addr (sweep_ff),
      .rd_data (stamp)
   );

   // age wraps modulo 2^TIME_BITS
   assign age   = now_ff - stamp;
   assign stale = CMP_W'(age) >= CMP_W'(delay_ff);

   always_comb begin
      state_in      = state_ff;
      present_in    = present_ff;
      delay_in      = csr_wr_en ? csr_wr_data : delay_ff;
      published_in  = published_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      found_in      = found_ff;
      sweep_in      = sweep_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = sweep_ff;
      total_in      = total_ff;
      below_in      = below_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_active_in = rsp_active_ff;
      ram_we        = 1'b0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // expire check: the stamp read issued from the sweep address is now on the RAM output
      if (chk_vld_ff && present_ff[chk_idx_ff]) begin
         if (stale) begin
            present_in[chk_idx_ff] = 1'b0;
         end else begin
            total_in = total_ff + CNT_W'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_action;
               key_in   = req_key;
               now_in   = now_t;
               found_in = key_in_range && present_ff[key_idx];
               sweep_in = '0;
               total_in = '0;
               below_in = '0;
               case (req_action)
                  aksr_pkg::ACT_EXPIRE: state_in = S_EXPIRE;
                  aksr_pkg::ACT_RANK:   state_in = S_RANK;
                  default: begin
                     // mark stamps the key; the unused code changes nothing
                     if (req_action == aksr_pkg::ACT_MARK && key_in_range) begin
                        ram_we              = 1'b1;
                        present_in[key_idx] = 1'b1;
                     end
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_EXPIRE: begin
            // issue the stamp read for sweep_ff, check it next cycle
            chk_vld_in = 1'b1;
            if (sweep_ff == LAST_IDX) begin
               state_in = S_EXP_LAST;
            end else begin
               sweep_in = sweep_ff + IDX_W'(1);
            end
         end
         S_EXP_LAST: begin
            state_in = S_RESULT;
         end
         S_RANK: begin
            if (present_ff[sweep_ff]) begin
               total_in = total_ff + CNT_W'(1);
               if (32'(sweep_ff) < 32'(key_ff)) begin
                  below_in = below_ff + CNT_W'(1);
               end
            end
            if (sweep_ff == LAST_IDX) begin
               state_in = S_RESULT;
            end else begin
               sweep_in = sweep_ff + IDX_W'(1);
            end
         end
         S_RESULT: begin
            // load the output register when it is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_rank_in   = '0;
               rsp_found_in  = 1'b0;
               rsp_active_in = published_ff;
               if (op_ff == aksr_pkg::ACT_EXPIRE) begin
                  published_in  = aksr_pkg::sat8(16'(total_ff));
                  rsp_active_in = aksr_pkg::sat8(16'(total_ff));
               end else if (op_ff == aksr_pkg::ACT_RANK) begin
                  rsp_found_in = found_ff;
                  rsp_rank_in  = found_ff ? aksr_pkg::sat8(16'(below_ff))
                                          : aksr_pkg::sat8(16'(total_ff));
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         present_ff   <= '0;
         delay_ff     <= aksr_pkg::DELAY_RESET;
         published_ff <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         delay_ff     <= delay_in;
         published_ff <= published_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset
      op_ff         <= op_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      found_ff      <= found_in;
      sweep_ff      <= sweep_in;
      chk_idx_ff    <= chk_idx_in;
      total_ff      <= total_in;
      below_ff      <= below_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rank         = rsp_rank_ff;
   assign rsp_key_present  = rsp_found_ff;
   assign rsp_active_count = rsp_active_ff;

endmodule

/* src/aksr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module aksr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
